FILE: design/tfcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_pkg
// Shared types, framing constants and the CRC-16/MCRF4XX byte update for the
// telemetry frame packer.
// ----------------------------------------------------------------------------
package tfcp_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] SYNC_0   = 8'hF1;
    localparam logic [7:0] SYNC_1   = 8'hF2;
    localparam logic [7:0] HDR_0    = 8'h00;
    localparam logic [7:0] HDR_1    = 8'h0C;
    localparam logic [7:0] TRAIL_0  = 8'hE3;
    localparam logic [7:0] TRAIL_1  = 8'hE4;

    // Byte positions within the emission sequence of one item.
    localparam logic [3:0] POS_SYNC_0  = 4'd0;
    localparam logic [3:0] POS_SYNC_1  = 4'd1;
    localparam logic [3:0] POS_HDR_0   = 4'd2;
    localparam logic [3:0] POS_HDR_1   = 4'd3;
    localparam logic [3:0] POS_DATA_0  = 4'd4;
    localparam logic [3:0] POS_DATA_1  = 4'd5;
    localparam logic [3:0] POS_DATA_2  = 4'd6;
    localparam logic [3:0] POS_DATA_3  = 4'd7;
    localparam logic [3:0] POS_CRC_LO  = 4'd8;
    localparam logic [3:0] POS_CRC_HI  = 4'd9;
    localparam logic [3:0] POS_TRAIL_0 = 4'd10;
    localparam logic [3:0] POS_TRAIL_1 = 4'd11;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [31:0] word;
        logic        first;
        logic        last;
    } t_item;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic [7:0]  d;
        c = crc;
        d = b;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

FILE: design/telemetry_frame_crc16_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_crc16_packer
// Packs 32-bit sensor words into framed byte packets with a CRC-16/MCRF4XX.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one sensor word per item.
// Output channel: o_valid / i_stall carry one packet byte per item, with
// o_packet_end high on the final trailer byte of each packet.
// A packet is F1 F2 00 0C, then each word least significant byte first,
// then CRC low, CRC high, E3 E4. The CRC covers every byte before it.
// A word accepted while the output is free passes through the queue and then
// the output register. The serializer emits one byte per cycle while the
// receiver does not stall, so a word costs 4 bytes, plus 4 for the header on
// the first word of a packet and 4 for the trailer on the last; the byte-wide
// output port sets this rate. A two-entry queue lets new words be accepted
// while bytes of earlier ones are still going out.
// When the receiver stalls, the current byte is held and the queue fills,
// after which o_stall is raised. Reset empties the queue, drops any pending
// output and restarts at the first word of a packet with the CRC preset.
// ----------------------------------------------------------------------------
module telemetry_frame_crc16_packer #(
    parameter int WORDS_PER_PACKET = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_sensor_word,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_packet_end
);
    import tfcp_pkg::*;

    logic  queue_full;
    logic  push;
    t_item push_item;
    logic  pop;
    logic  head_valid;
    t_item head;

    tfcp_front #(
        .WORDS_PER_PACKET (WORDS_PER_PACKET)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sensor_word (i_sensor_word),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_item        (push_item)
    );

    tfcp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (push_item),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    tfcp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end)
    );

endmodule

FILE: design/tfcp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_front
// Accepts sensor words, tracks the position within the packet and tags each
// item as the first and/or last word of its packet.
// ----------------------------------------------------------------------------
module tfcp_front #(
    parameter int WORDS_PER_PACKET = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_sensor_word,
    input  logic                i_queue_full,
    output logic                o_push,
    output tfcp_pkg::t_item     o_item
);
    import tfcp_pkg::*;

    // A packet must span at least two words and the 4-bit index covers at most 16.
    localparam int WPP_EFF = (WORDS_PER_PACKET < 2) ? 2 :
                             ((WORDS_PER_PACKET > 16) ? 16 : WORDS_PER_PACKET);
    localparam logic [3:0] LAST_IDX = 4'(WPP_EFF - 1);

    logic [3:0] r_word_index;
    logic [3:0] n_word_index;
    logic       last;

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;
    assign last    = (r_word_index >= LAST_IDX);

    assign o_item.word  = i_sensor_word;
    assign o_item.first = (r_word_index == 4'd0);
    assign o_item.last  = last;

    always_comb begin
        n_word_index = r_word_index;
        if (o_push) begin
            n_word_index = last ? 4'd0 : r_word_index + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_index <= 4'd0;
        end else begin
            r_word_index <= n_word_index;
        end
    end

endmodule

FILE: design/tfcp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_queue
// Short first-in first-out buffer of classified items between the front and
// the byte serializer.
// ----------------------------------------------------------------------------
module tfcp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tfcp_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_head_valid,
    output tfcp_pkg::t_item  o_head
);
    import tfcp_pkg::*;

    t_item                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic [QUEUE_AW-1:0]   n_wr_ptr;
    logic [QUEUE_AW-1:0]   n_rd_ptr;
    logic [QUEUE_AW:0]     n_count;

    assign o_full       = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: design/tfcp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_back
// Byte serializer: emits header, data, CRC and trailer bytes of each packet,
// one per cycle unless stalled, to an output register; keeps the running CRC.
// ----------------------------------------------------------------------------
module tfcp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  tfcp_pkg::t_item  i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_packet_end
);
    import tfcp_pkg::*;

    logic [3:0]  r_pos;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_end;

    logic [3:0]  n_pos;
    logic [15:0] n_crc;
    logic        n_out_valid;
    logic [3:0]  cur_pos;
    logic [7:0]  cur_byte;
    logic [15:0] crc_base;
    logic        load;
    logic        item_done;

    assign load = i_head_valid && (!r_out_valid || !i_stall);

    // An item that does not open a packet skips the four header positions.
    assign cur_pos  = (r_pos == POS_SYNC_0 && !i_head.first) ? POS_DATA_0 : r_pos;
    assign crc_base = (cur_pos == POS_SYNC_0) ? CRC_INIT : r_crc;

    always_comb begin
        unique case (cur_pos)
            POS_SYNC_0:  cur_byte = SYNC_0;
            POS_SYNC_1:  cur_byte = SYNC_1;
            POS_HDR_0:   cur_byte = HDR_0;
            POS_HDR_1:   cur_byte = HDR_1;
            POS_DATA_0:  cur_byte = i_head.word[7:0];
            POS_DATA_1:  cur_byte = i_head.word[15:8];
            POS_DATA_2:  cur_byte = i_head.word[23:16];
            POS_DATA_3:  cur_byte = i_head.word[31:24];
            POS_CRC_LO:  cur_byte = r_crc[7:0];
            POS_CRC_HI:  cur_byte = r_crc[15:8];
            POS_TRAIL_0: cur_byte = TRAIL_0;
            POS_TRAIL_1: cur_byte = TRAIL_1;
            default:     cur_byte = 8'h00;
        endcase
    end

    assign item_done = (cur_pos == POS_TRAIL_1) || (cur_pos == POS_DATA_3 && !i_head.last);
    assign o_pop     = load && item_done;

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_out_valid = r_out_valid && i_stall;
        if (load) begin
            n_out_valid = 1'b1;
            n_pos       = item_done ? POS_SYNC_0 : cur_pos + 4'd1;
            // Only sync, header and data bytes enter the checksum.
            if (cur_pos < POS_CRC_LO) begin
                n_crc = crc_byte(crc_base, cur_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= cur_byte;
            r_out_end  <= (cur_pos == POS_TRAIL_1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_SYNC_0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_packet_end = r_out_end;

endmodule
